/* rtl/core/longest_remaining_job_selector_core_assert.svh */
// Assertion macros for the longest remaining job selector.
// Included by the core module, which carries the concurrent assertions; needs nothing else.
`ifndef LONGEST_REMAINING_JOB_SELECTOR_CORE_ASSERT_SVH
`define LONGEST_REMAINING_JOB_SELECTOR_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define LRJS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define LRJS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define LRJS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lrjs_pkg.sv */
// Shared types and constants for the longest remaining job selector.
// Used by the core, the result checker and the testbench; depends on nothing.
`timescale 1ns / 1ps

package lrjs_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int ID_W            = 16;
	localparam int REM_W           = 16;
	localparam int ENTRY_W         = ID_W + REM_W;

	localparam logic       REQ_ARRIVAL  = 1'b0;
	localparam logic       REQ_SCHEDULE = 1'b1;

	localparam logic [1:0] ST_READY    = 2'd0;
	localparam logic [1:0] ST_BLOCKED  = 2'd1;
	localparam logic [1:0] ST_FINISHED = 2'd2;

	localparam logic [2:0] DEST_NONE     = 3'd0;
	localparam logic [2:0] DEST_READY    = 3'd1;
	localparam logic [2:0] DEST_BLOCKED  = 3'd2;
	localparam logic [2:0] DEST_FINISHED = 3'd3;
	localparam logic [2:0] DEST_BAD      = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SLAST,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

/* rtl/core/lrjs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Holds the ready table; depends on nothing.
`timescale 1ns / 1ps

module lrjs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/longest_remaining_job_selector_core.sv */
// Top level of the longest remaining job selector: sequencer, shared comparator
// and ready table. Depends on lrjs_pkg, lrjs_ram and the assertion macro header.
//
// Channel   Direction  Handshake          Fields
// request   in         start, busy        req_type, has_current, current_state,
//                                         proc_id, proc_remaining
// result    out        done (one cycle)   selected_valid, selected_id,
//                                         selected_remaining, current_dest,
//                                         insert_dropped
//
// A transaction is taken when start is high and busy is low; busy then stays high
// through the result cycle. An arrival, or a schedule call that leaves the table
// empty, goes straight to the result cycle. A schedule call over a non-empty table
// (after routing the returning process) first scans every entry: one comparator
// reads the table RAM once per cycle to find the longest job, then the same read
// port shifts the entries behind the chosen one down to close the gap.
// done is high for exactly one cycle and cannot be held off. Reset empties the table.
`timescale 1ns / 1ps

`include "longest_remaining_job_selector_core_assert.svh"

module longest_remaining_job_selector_core #(
	parameter int TABLE_DEPTH = lrjs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       req_type,
	input  logic                       has_current,
	input  logic [1:0]                 current_state,
	input  logic [lrjs_pkg::ID_W-1:0]  proc_id,
	input  logic [lrjs_pkg::REM_W-1:0] proc_remaining,
	output logic                       done,
	output logic                       selected_valid,
	output logic [lrjs_pkg::ID_W-1:0]  selected_id,
	output logic [lrjs_pkg::REM_W-1:0] selected_remaining,
	output logic [2:0]                 current_dest,
	output logic                       insert_dropped
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

	lrjs_pkg::state_t state_q, state_d;

	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                ptr_q;
	logic                         rv_s1;
	logic [IW-1:0]                idx_s1;
	logic [IW-1:0]                best_idx_q;
	logic [lrjs_pkg::ID_W-1:0]    best_id_q;
	logic [lrjs_pkg::REM_W-1:0]   best_rem_q;
	logic                         sel_valid_q;
	logic [2:0]                   dest_q;
	logic                         drop_q;

	logic                         accept;
	logic                         want_append;
	logic                         full;
	logic                         do_append;
	logic [CW-1:0]                cnt_after;
	logic [2:0]                   dest_d;
	logic                         issue;
	logic [CW-1:0]                ptr_limit;
	logic                         we;
	logic [IW-1:0]                waddr;
	logic [lrjs_pkg::ENTRY_W-1:0] wdata;
	logic [IW-1:0]                raddr;
	logic [lrjs_pkg::ENTRY_W-1:0] rdata;
	logic [lrjs_pkg::ID_W-1:0]    rd_id;
	logic [lrjs_pkg::REM_W-1:0]   rd_rem;
	logic                         comparing;
	logic                         take;
	logic [IW-1:0]                new_best;

	assign accept      = start && !busy;
	assign busy        = (state_q != lrjs_pkg::S_IDLE);
	assign full        = (cnt_q == FULL_CNT);
	assign want_append = (req_type == lrjs_pkg::REQ_ARRIVAL) ||
	                     (has_current && current_state == lrjs_pkg::ST_READY);
	assign do_append   = want_append && !full;
	assign cnt_after   = cnt_q + CW'(do_append);

	always_comb begin
		if (req_type == lrjs_pkg::REQ_ARRIVAL || !has_current) begin
			dest_d = lrjs_pkg::DEST_NONE;
		end else begin
			unique case (current_state)
				lrjs_pkg::ST_READY:    dest_d = lrjs_pkg::DEST_READY;
				lrjs_pkg::ST_BLOCKED:  dest_d = lrjs_pkg::DEST_BLOCKED;
				lrjs_pkg::ST_FINISHED: dest_d = lrjs_pkg::DEST_FINISHED;
				default:               dest_d = lrjs_pkg::DEST_BAD;
			endcase
		end
	end

	// Shared comparator: the first entry always wins, later ones only if strictly
	// longer, so ties stay with the earliest inserted entry.
	assign rd_id     = rdata[lrjs_pkg::ENTRY_W-1:lrjs_pkg::REM_W];
	assign rd_rem    = rdata[lrjs_pkg::REM_W-1:0];
	assign comparing = (state_q == lrjs_pkg::S_SCAN) || (state_q == lrjs_pkg::S_SLAST);
	assign take      = comparing && rv_s1 && ((idx_s1 == '0) || (rd_rem > best_rem_q));
	assign new_best  = take ? idx_s1 : best_idx_q;
	assign ptr_limit = (state_q == lrjs_pkg::S_SCAN) ? (cnt_q - CW'(1)) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrjs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		we      = 1'b0;
		waddr   = idx_s1 - IW'(1);
		wdata   = rdata;
		raddr   = ptr_q[IW-1:0];
		unique case (state_q)
			lrjs_pkg::S_IDLE: begin
				waddr = cnt_q[IW-1:0];
				wdata = {proc_id, proc_remaining};
				we    = accept && do_append;
				if (accept) begin
					if (req_type == lrjs_pkg::REQ_SCHEDULE && cnt_after != '0) begin
						state_d = lrjs_pkg::S_SCAN;
					end else begin
						state_d = lrjs_pkg::S_DONE;
					end
				end
			end
			lrjs_pkg::S_SCAN: begin
				issue = 1'b1;
				if (ptr_q == ptr_limit) begin
					state_d = lrjs_pkg::S_SLAST;
				end
			end
			lrjs_pkg::S_SLAST: begin
				state_d = lrjs_pkg::S_SHIFT;
			end
			lrjs_pkg::S_SHIFT: begin
				// Issue the read of entry j while entry j-1, read in the previous cycle, is written into entry j-2.
				we    = rv_s1;
				issue = (ptr_q != ptr_limit);
				if (ptr_q == ptr_limit) begin
					state_d = lrjs_pkg::S_DONE;
				end
			end
			lrjs_pkg::S_DONE: begin
				state_d = lrjs_pkg::S_IDLE;
			end
			default: begin
				state_d = lrjs_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ptr_q       <= '0;
			rv_s1       <= 1'b0;
			sel_valid_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			unique case (state_q)
				lrjs_pkg::S_IDLE: begin
					if (accept) begin
						cnt_q       <= cnt_after;
						ptr_q       <= '0;
						sel_valid_q <= (req_type == lrjs_pkg::REQ_SCHEDULE) && (cnt_after != '0);
					end
				end
				lrjs_pkg::S_SLAST: begin
					ptr_q <= CW'(new_best) + CW'(1);
				end
				lrjs_pkg::S_DONE: begin
					if (sel_valid_q) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q[IW-1:0];
		if (accept) begin
			best_idx_q <= '0;
			best_id_q  <= '0;
			best_rem_q <= '0;
			dest_q     <= dest_d;
			drop_q     <= want_append && full;
		end else if (take) begin
			best_idx_q <= idx_s1;
			best_id_q  <= rd_id;
			best_rem_q <= rd_rem;
		end
	end

	lrjs_ram #(
		.WIDTH(lrjs_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign done               = (state_q == lrjs_pkg::S_DONE);
	assign selected_valid     = sel_valid_q;
	assign selected_id        = best_id_q;
	assign selected_remaining = best_rem_q;
	assign current_dest       = dest_q;
	assign insert_dropped     = drop_q;

	`LRJS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= FULL_CNT, "entry count beyond table depth")
	`LRJS_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`LRJS_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "busy not raised after a transaction")
	`LRJS_ASSERT_IMP(a_write_in_table, clk, arst_n, we && busy, CW'(waddr) < cnt_q, "shift write outside the occupied table")
	`LRJS_ASSERT_IMP(a_none_zero, clk, arst_n, done && !selected_valid, selected_id == '0 && selected_remaining == '0, "empty selection carries data")

endmodule

/* sim/lrjs_result_checker.sv */
// Result checker for the longest remaining job selector: watches both channels,
// keeps its own copy of the ready table and compares every result it predicts.
// Depends on lrjs_pkg for widths and codes.
`timescale 1ns / 1ps

module lrjs_result_checker import lrjs_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             req_type,
	input  logic             has_current,
	input  logic [1:0]       current_state,
	input  logic [ID_W-1:0]  proc_id,
	input  logic [REM_W-1:0] proc_remaining,
	input  logic             done,
	input  logic             selected_valid,
	input  logic [ID_W-1:0]  selected_id,
	input  logic [REM_W-1:0] selected_remaining,
	input  logic [2:0]       current_dest,
	input  logic             insert_dropped,
	output int               fail_count,
	output int               pending,
	output int               checked,
	output int               picks,
	output int               empty_picks,
	output int               drops
);

	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [REM_W-1:0] remaining;
		logic [2:0]       dest;
		logic             dropped;
	} job_result_t;

	logic [ID_W-1:0]  ready_id  [DEPTH];
	logic [REM_W-1:0] ready_rem [DEPTH];
	int               ready_count;
	job_result_t      pending_results[$];

	// Returns 1 when the table is full and the entry is lost.
	function automatic logic append_job(input logic [ID_W-1:0] id,
			input logic [REM_W-1:0] rem);
		if (ready_count >= DEPTH)
			return 1'b1;
		ready_id[ready_count]  = id;
		ready_rem[ready_count] = rem;
		ready_count++;
		return 1'b0;
	endfunction

	function automatic job_result_t pick_longest_job(input logic rt, input logic hc,
			input logic [1:0] st, input logic [ID_W-1:0] id,
			input logic [REM_W-1:0] rem);
		job_result_t r;
		int          best;
		r = '0;
		if (rt == REQ_ARRIVAL) begin
			r.dropped = append_job(id, rem);
		end else begin
			if (hc) begin
				case (st)
					ST_READY: begin
						r.dest    = DEST_READY;
						r.dropped = append_job(id, rem);
					end
					ST_BLOCKED:  r.dest = DEST_BLOCKED;
					ST_FINISHED: r.dest = DEST_FINISHED;
					default:     r.dest = DEST_BAD;
				endcase
			end
			if (ready_count > 0) begin
				// Strictly greater keeps the earliest inserted entry on a tie.
				best = 0;
				for (int i = 1; i < ready_count; i++)
					if (ready_rem[i] > ready_rem[best])
						best = i;
				r.valid     = 1'b1;
				r.id        = ready_id[best];
				r.remaining = ready_rem[best];
				for (int i = best; i + 1 < ready_count; i++) begin
					ready_id[i]  = ready_id[i + 1];
					ready_rem[i] = ready_rem[i + 1];
				end
				ready_count--;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		job_result_t exp_r;
		if (!arst_n) begin
			ready_count = 0;
			pending_results.delete();
			fail_count  = 0;
			pending     = 0;
			checked     = 0;
			picks       = 0;
			empty_picks = 0;
			drops       = 0;
		end else begin
			// The result for a transaction always comes in a later cycle than the transaction,
			// so the result side is handled before a new transaction is predicted.
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no request outstanding");
					fail_count++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("selected_valid", 32'(exp_r.valid), 32'(selected_valid));
					check_field("selected_id", 32'(exp_r.id), 32'(selected_id));
					check_field("selected_remaining", 32'(exp_r.remaining),
						32'(selected_remaining));
					check_field("current_dest", 32'(exp_r.dest), 32'(current_dest));
					check_field("insert_dropped", 32'(exp_r.dropped), 32'(insert_dropped));
					checked++;
					if (exp_r.dropped)
						drops++;
					if (req_type == REQ_SCHEDULE || exp_r.valid) begin
						if (exp_r.valid)
							picks++;
					end
				end
			end
			if (start && !busy) begin
				exp_r = pick_longest_job(req_type, has_current, current_state, proc_id,
					proc_remaining);
				if (req_type == REQ_SCHEDULE && !exp_r.valid)
					empty_picks++;
				pending_results.push_back(exp_r);
			end
			pending = pending_results.size();
		end
	end

endmodule

/* sim/tb_longest_remaining_job_selector_core.sv */
// Testbench top for the longest remaining job selector: drives directed and random
// request transactions in bursts and gives the verdict.
// Depends on lrjs_pkg, the core RTL and lrjs_result_checker.
`timescale 1ns / 1ps

module tb_longest_remaining_job_selector_core;
	import lrjs_pkg::*;

	localparam logic [1:0] ST_INVALID = 2'd3;
	localparam int         RANDOM_ITEMS = 1330;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             req_type = REQ_ARRIVAL;
	logic             has_current = 1'b0;
	logic [1:0]       current_state = ST_READY;
	logic [ID_W-1:0]  proc_id = '0;
	logic [REM_W-1:0] proc_remaining = '0;
	logic             done;
	logic             selected_valid;
	logic [ID_W-1:0]  selected_id;
	logic [REM_W-1:0] selected_remaining;
	logic [2:0]       current_dest;
	logic             insert_dropped;

	int fail_count, pending, checked, picks, empty_picks, drops;
	int sent = 0;
	int arrivals = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	longest_remaining_job_selector_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.req_type           (req_type),
		.has_current        (has_current),
		.current_state      (current_state),
		.proc_id            (proc_id),
		.proc_remaining     (proc_remaining),
		.done               (done),
		.selected_valid     (selected_valid),
		.selected_id        (selected_id),
		.selected_remaining (selected_remaining),
		.current_dest       (current_dest),
		.insert_dropped     (insert_dropped)
	);

	lrjs_result_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.req_type           (req_type),
		.has_current        (has_current),
		.current_state      (current_state),
		.proc_id            (proc_id),
		.proc_remaining     (proc_remaining),
		.done               (done),
		.selected_valid     (selected_valid),
		.selected_id        (selected_id),
		.selected_remaining (selected_remaining),
		.current_dest       (current_dest),
		.insert_dropped     (insert_dropped),
		.fail_count         (fail_count),
		.pending            (pending),
		.checked            (checked),
		.picks              (picks),
		.empty_picks        (empty_picks),
		.drops              (drops)
	);

	// Drives one request transaction and returns just after the edge that takes it, or,
	// at the end of a burst, after dropping start for a random gap. busy only moves on a
	// rising edge, so its value at the falling edge is the one the next rising edge sees.
	task automatic issue_request(input logic rt, input logic hc, input logic [1:0] st,
			input logic [ID_W-1:0] id, input logic [REM_W-1:0] rem);
		@(negedge clk);
		req_type       = rt;
		has_current    = hc;
		current_state  = st;
		proc_id        = id;
		proc_remaining = rem;
		start          = 1'b1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent++;
		if (rt == REQ_ARRIVAL)
			arrivals++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			start          = 1'b0;
			proc_id        = 16'($urandom);
			proc_remaining = 16'($urandom);
			// Mostly short gaps, some long enough to outlast a full table scan.
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 45) : $urandom_range(0, 4))
				@(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// Small ranges give plenty of ties; the extremes test the comparator edges.
	function automatic logic [REM_W-1:0] random_remaining();
		case ($urandom_range(0, 3))
			0:       return 16'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return 16'h0001;
					2:       return 16'hFFFE;
					default: return 16'hFFFF;
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int               arrival_pct;
		int               phase_len;
		logic             rt;
		logic             hc;
		logic [1:0]       st;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Selections and routing on an empty table.
		issue_request(REQ_SCHEDULE, 1'b0, ST_INVALID, 16'hFFFF, 16'hFFFF);
		issue_request(REQ_SCHEDULE, 1'b1, ST_BLOCKED, 16'h1111, 16'h2222);
		issue_request(REQ_SCHEDULE, 1'b1, ST_FINISHED, 16'h3333, 16'h4444);
		issue_request(REQ_SCHEDULE, 1'b1, ST_INVALID, 16'h5555, 16'h6666);
		// A returning ready process is queued and then chosen at once.
		issue_request(REQ_SCHEDULE, 1'b1, ST_READY, 16'hABCD, 16'h0000);
		// An arrival ignores the returning process fields.
		issue_request(REQ_ARRIVAL, 1'b1, ST_INVALID, 16'hFFFF, 16'hFFFF);
		issue_request(REQ_ARRIVAL, 1'b0, ST_READY, 16'h0000, 16'h0000);
		// Fill the table with plenty of ties, including one on the maximum.
		for (int i = 0; i < 14; i++)
			issue_request(REQ_ARRIVAL, 1'(i), 2'(i), 16'h1000 + 16'(i),
				(i % 4 == 0) ? 16'hFFFF : 16'h0100 + 16'(i % 2));
		// Both ways of inserting into a full table.
		issue_request(REQ_ARRIVAL, 1'b0, ST_READY, 16'hDEAD, 16'hFFFF);
		issue_request(REQ_SCHEDULE, 1'b1, ST_READY, 16'hBEEF, 16'hFFFF);
		issue_request(REQ_SCHEDULE, 1'b0, ST_READY, 16'h0000, 16'h0000);
		issue_request(REQ_SCHEDULE, 1'b1, ST_BLOCKED, 16'h0000, 16'h0000);

		// Phases that fill, drain or hold the table so it reaches both full and empty.
		while (sent < RANDOM_ITEMS + 25) begin
			case ($urandom_range(0, 2))
				0:       arrival_pct = 80;
				1:       arrival_pct = 15;
				default: arrival_pct = 45;
			endcase
			phase_len = $urandom_range(10, 60);
			repeat (phase_len) begin
				rt = ($urandom_range(0, 99) < arrival_pct) ? REQ_ARRIVAL : REQ_SCHEDULE;
				hc = ($urandom_range(0, 3) != 0);
				st = ($urandom_range(0, 9) < 6) ? ST_READY : 2'($urandom_range(1, 3));
				issue_request(rt, hc, st, 16'($urandom), random_remaining());
			end
		end

		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4 * TABLE_DEPTH_DEF) @(negedge clk);

		$display("Sent %0d request transactions (%0d arrivals, %0d schedule calls).",
			sent, arrivals, sent - arrivals);
		$display("Checked %0d results: %0d selections, %0d on an empty table, %0d drops.",
			checked, picks, empty_picks, drops);
		if (fail_count == 0) begin
			$display("longest_remaining_job_selector_core verification clean");
		end else begin
			$display("longest_remaining_job_selector_core verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding.", pending);
		$display("longest_remaining_job_selector_core verification failed");
		$finish;
	end

endmodule
